[rtl/esd_pkg.sv]
// esd_pkg: types, character codes and helper functions for the escape sequence decoder
// no dependencies

package esd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_DIGITS = 2'd2,
    MODE_COPY   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] DIGIT_ZERO   = 8'd48;
  localparam logic [7:0] DIGIT_END    = 8'd58;
  localparam logic [2:0] U_COPY_LEN   = 3'd4;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_map_t;

  function automatic esc_map_t simple_escape(input logic [7:0] b);
    esc_map_t m;
    m.hit   = 1'b1;
    m.value = b;
    unique case (b)
      CH_SLASH, CH_QUOTE, CH_BACKSLASH: m.value = b;
      CH_A:    m.value = 8'd7;
      CH_B:    m.value = 8'd8;
      CH_F:    m.value = 8'd12;
      CH_N:    m.value = 8'd10;
      CH_R:    m.value = 8'd13;
      CH_T:    m.value = 8'd9;
      CH_V:    m.value = 8'd11;
      default: m.hit   = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DIGIT_ZERO) && (b < DIGIT_END);
  endfunction

endpackage

[rtl/esd_if.sv]
// esd_in_if, esd_out_if: valid/ready channels of the escape sequence decoder
// no dependencies

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/escape_sequence_decoder.sv]
// escape_sequence_decoder: streaming backslash unescape, one word in per cycle
// unless stalled; depends on esd_pkg and the channel interfaces in esd_if.sv

// Takes an escaped string one byte per word (in_last on the final byte) and
// gives the unescaped bytes. Each accepted word lands in an input register,
// is decoded combinationally and its zero, one or two result words are pushed
// into a two-entry output queue; a result thus passes the input register
// and then the output queue. Sustained rate is one input word per cycle as
// long as the output side takes one word per cycle; the output queue drains
// one word per cycle, so a word that yields two results (\u, unknown
// escape, end of a digit run) can hold the input back.
module escape_sequence_decoder (
  input  logic        clk,
  input  logic        rst_n,
  esd_in_if.sink      in_ch,
  esd_out_if.source   out_ch
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;

  esd_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]          octal_r, octal_nxt;
  logic [2:0]          copy_r, copy_nxt;

  logic [7:0]          q_byte_r [2];
  logic                q_last_r [2];
  logic [7:0]          q_byte_nxt [2];
  logic                q_last_nxt [2];
  logic [1:0]          count_r, count_nxt;

  logic [1:0]          res_n;
  logic [7:0]          res0_byte, res1_byte;
  logic                res0_last, res1_last;

  logic                pop;
  logic [1:0]          count_left;
  logic                consume;
  logic                accept;

  esd_pkg::esc_map_t   esc;
  logic                dig;
  logic [7:0]          dig_val;
  logic [7:0]          run_val;

  assign esc     = esd_pkg::simple_escape(in_byte_r);
  assign dig     = esd_pkg::is_digit(in_byte_r);
  assign dig_val = {4'd0, in_byte_r[3:0]};
  assign run_val = {octal_r[4:0], 3'd0} + dig_val;

  assign pop        = out_ch.valid && out_ch.ready;
  assign count_left = count_r - {1'b0, pop};
  assign consume    = in_valid_r && (({1'b0, count_left} + {1'b0, res_n}) <= 3'd2);
  assign in_ch.ready = !in_valid_r || consume;
  assign accept     = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = (count_r != 2'd0);
  assign out_ch.out_byte = q_byte_r[0];
  assign out_ch.out_last = q_last_r[0];

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    octal_nxt = octal_r;
    copy_nxt  = copy_r;
    if (consume) begin
      unique case (mode_r)
        esd_pkg::MODE_NORMAL: begin
          mode_nxt = (in_byte_r == esd_pkg::CH_BACKSLASH && !in_last_r) ?
                     esd_pkg::MODE_ESCAPE : esd_pkg::MODE_NORMAL;
        end
        esd_pkg::MODE_ESCAPE: begin
          if (esc.hit) begin
            mode_nxt = esd_pkg::MODE_NORMAL;
          end else if (in_byte_r == esd_pkg::CH_U) begin
            mode_nxt = in_last_r ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_COPY;
            copy_nxt = in_last_r ? 3'd0 : esd_pkg::U_COPY_LEN;
          end else if (dig) begin
            mode_nxt  = in_last_r ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_DIGITS;
            octal_nxt = in_last_r ? 8'd0 : dig_val;
          end else begin
            mode_nxt = esd_pkg::MODE_NORMAL;
          end
        end
        esd_pkg::MODE_DIGITS: begin
          if (dig) begin
            mode_nxt  = in_last_r ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_DIGITS;
            octal_nxt = in_last_r ? 8'd0 : run_val;
          end else begin
            octal_nxt = 8'd0;
            mode_nxt  = (in_byte_r == esd_pkg::CH_BACKSLASH && !in_last_r) ?
                        esd_pkg::MODE_ESCAPE : esd_pkg::MODE_NORMAL;
          end
        end
        esd_pkg::MODE_COPY: begin
          if (in_last_r || copy_r <= 3'd1) begin
            mode_nxt = esd_pkg::MODE_NORMAL;
            copy_nxt = 3'd0;
          end else begin
            copy_nxt = copy_r - 3'd1;
          end
        end
        default: mode_nxt = esd_pkg::MODE_NORMAL;
      endcase
    end
  end

  // result words of the word in the input register
  always_comb begin
    res_n     = 2'd0;
    res0_byte = in_byte_r;
    res0_last = in_last_r;
    res1_byte = in_byte_r;
    res1_last = in_last_r;
    unique case (mode_r)
      esd_pkg::MODE_NORMAL: begin
        res_n = (in_byte_r == esd_pkg::CH_BACKSLASH && !in_last_r) ? 2'd0 : 2'd1;
      end
      esd_pkg::MODE_ESCAPE: begin
        if (esc.hit) begin
          res_n     = 2'd1;
          res0_byte = esc.value;
        end else if (dig) begin
          res_n     = in_last_r ? 2'd1 : 2'd0;
          res0_byte = dig_val;
        end else begin
          res_n     = 2'd2;
          res0_byte = esd_pkg::CH_BACKSLASH;
          res0_last = 1'b0;
        end
      end
      esd_pkg::MODE_DIGITS: begin
        if (dig) begin
          res_n     = in_last_r ? 2'd1 : 2'd0;
          res0_byte = run_val;
        end else begin
          res0_byte = octal_r;
          res0_last = 1'b0;
          res_n     = (in_byte_r == esd_pkg::CH_BACKSLASH && !in_last_r) ? 2'd1 : 2'd2;
        end
      end
      esd_pkg::MODE_COPY: begin
        res_n = 2'd1;
      end
      default: res_n = 2'd0;
    endcase
  end

  // output queue, head at entry 0
  always_comb begin
    q_byte_nxt = q_byte_r;
    q_last_nxt = q_last_r;
    if (pop) begin
      q_byte_nxt[0] = q_byte_r[1];
      q_last_nxt[0] = q_last_r[1];
    end
    if (consume && res_n != 2'd0) begin
      q_byte_nxt[count_left[0]] = res0_byte;
      q_last_nxt[count_left[0]] = res0_last;
      if (res_n == 2'd2) begin
        q_byte_nxt[1] = res1_byte;
        q_last_nxt[1] = res1_last;
      end
    end
    count_nxt = consume ? (count_left + res_n) : count_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= esd_pkg::MODE_NORMAL;
      octal_r    <= 8'd0;
      copy_r     <= 3'd0;
      count_r    <= 2'd0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (consume) begin
        in_valid_r <= 1'b0;
      end
      mode_r  <= mode_nxt;
      octal_r <= octal_nxt;
      copy_r  <= copy_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.in_last;
    end
    q_byte_r <= q_byte_nxt;
    q_last_r <= q_last_nxt;
  end

endmodule

[rtl/esd_checker.sv]
// esd_checker: port-level assertions for escape_sequence_decoder, and its bind
// depends on escape_sequence_decoder and the channel interfaces

module esd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing waiting at the output");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last && !out_valid |=> ##1 out_valid)
    else $error("final word of a string gave no result in time");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
